FILE: rtl/core/npc_pkg.sv
// Package for the nearest palette color unit: widths, beat types, palette ROM.
// No dependencies.
package npc_pkg;

  localparam int unsigned ROM_SIZE            = 18;
  localparam int unsigned PALETTE_ENTRIES_DEF = 18;
  localparam int unsigned IDX_W               = 5;
  localparam int unsigned CHAN_W              = 8;
  localparam int unsigned SQ_W                = 2 * CHAN_W;
  localparam int unsigned DIST_W              = SQ_W + 2;
  localparam int unsigned LEN_W               = 4;
  localparam int unsigned NUM_CHARS           = 8;

  // larger than any real distance (3 * 255^2), so the first entry always wins
  localparam logic [DIST_W-1:0] DIST_INIT = '1;

  localparam logic [7:0] CHAR_HASH = 8'h23;
  localparam logic [7:0] CHAR_ZERO = 8'h30;

  typedef logic [3*CHAN_W-1:0] rgb_t;

  localparam rgb_t PALETTE_ROM [ROM_SIZE] = '{
    24'hFFFFFF, 24'h000000, 24'h808080, 24'hC0C0C0, 24'hE02020, 24'hC12E1F,
    24'h0055FF, 24'h000080, 24'h00BFFF, 24'h10B010, 24'h32CD32, 24'hFFDF00,
    24'hFF8800, 24'h800080, 24'hFF69B4, 24'h8B4513, 24'hD4AF37, 24'hF0F8FF
  };

  // what moves from cell to cell
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [DIST_W-1:0] best_dist;
    logic [IDX_W-1:0]  best_idx;
    logic              unknown;
  } npc_beat_t;

endpackage

FILE: rtl/core/npc_if.sv
// Valid/ready channel interfaces for the nearest palette color unit.
// Depends on npc_pkg.
interface npc_in_if import npc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEN_W-1:0]   text_length;
  logic [7:0]         char_0;
  logic [7:0]         char_1;
  logic [7:0]         char_2;
  logic [7:0]         char_3;
  logic [7:0]         char_4;
  logic [7:0]         char_5;
  logic [7:0]         char_6;
  logic [7:0]         char_7;

  modport source (output valid, text_length, char_0, char_1, char_2, char_3,
                  char_4, char_5, char_6, char_7, input ready);
  modport sink   (input valid, text_length, char_0, char_1, char_2, char_3,
                  char_4, char_5, char_6, char_7, output ready);
endinterface

interface npc_out_if import npc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] palette_index;
  logic             unknown_flag;

  modport source (output valid, palette_index, unknown_flag, input ready);
  modport sink   (input valid, palette_index, unknown_flag, output ready);
endinterface

FILE: rtl/core/npc_decode.sv
// Front stage: strips the prefix, decodes six hex digits into RGB, flags short strings.
// Depends on npc_pkg and npc_in_if.
module npc_decode import npc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  npc_in_if.sink     in_i,
  output logic       valid_o,
  input  logic       ready_i,
  output npc_beat_t  beat_o
);

  function automatic logic [3:0] hex_val(input logic [7:0] ch);
    logic [3:0] v;
    v = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) v = 4'(ch - 8'h30);
    else if (ch >= 8'h61 && ch <= 8'h66) v = 4'(ch - 8'h57);
    else if (ch >= 8'h41 && ch <= 8'h46) v = 4'(ch - 8'h37);
    return v;
  endfunction

  logic [7:0]       chars [NUM_CHARS];
  logic [1:0]       off;
  logic [LEN_W-1:0] remain;
  logic [2:0]       pos   [6];
  logic [3:0]       nib   [6];
  logic             unknown;
  npc_beat_t        beat_d, beat_q;
  logic             valid_q;

  assign chars[0] = in_i.char_0;
  assign chars[1] = in_i.char_1;
  assign chars[2] = in_i.char_2;
  assign chars[3] = in_i.char_3;
  assign chars[4] = in_i.char_4;
  assign chars[5] = in_i.char_5;
  assign chars[6] = in_i.char_6;
  assign chars[7] = in_i.char_7;

  always_comb begin
    off    = (chars[0] == CHAR_HASH) ? 2'd1 : 2'd0;
    remain = in_i.text_length - LEN_W'(off);
    if (remain == LEN_W'(7) && chars[{1'b0, off}] == CHAR_ZERO) begin
      off = off + 2'd1;
    end
    // text_length >= 6 guards the subtraction against wrap
    unknown = (in_i.text_length < LEN_W'(6)) ||
              ((in_i.text_length - LEN_W'(off)) < LEN_W'(6));
    for (int k = 0; k < 6; k++) begin
      pos[k] = {1'b0, off} + 3'(k);
      nib[k] = hex_val(chars[pos[k]]);
    end
    beat_d.red       = {nib[0], nib[1]};
    beat_d.green     = {nib[2], nib[3]};
    beat_d.blue      = {nib[4], nib[5]};
    beat_d.best_dist = DIST_INIT;
    beat_d.best_idx  = '0;
    beat_d.unknown   = unknown;
  end

  assign in_i.ready = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

FILE: rtl/core/npc_cell.sv
// One cell of the search chain: compares the color with one palette entry, or passes the beat on past the ROM.
// Depends on npc_pkg.
module npc_cell import npc_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  npc_beat_t beat_i,
  output logic      valid_o,
  input  logic      ready_i,
  output npc_beat_t beat_o
);

  npc_beat_t beat_d, beat_q;
  logic      valid_q;

  if (IDX < ROM_SIZE) begin : g_entry
    localparam rgb_t ENTRY = PALETTE_ROM[IDX];

    function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b);
      logic [CHAN_W-1:0] d;
      d = (a >= b) ? (a - b) : (b - a);
      return SQ_W'(d) * SQ_W'(d);
    endfunction

    logic [DIST_W-1:0] distance;

    always_comb begin
      distance = DIST_W'(sq_diff(beat_i.red,   ENTRY[3*CHAN_W-1:2*CHAN_W])) +
                 DIST_W'(sq_diff(beat_i.green, ENTRY[2*CHAN_W-1:CHAN_W])) +
                 DIST_W'(sq_diff(beat_i.blue,  ENTRY[CHAN_W-1:0]));
      beat_d = beat_i;
      // strict compare keeps the earliest entry on ties
      if (!beat_i.unknown && distance < beat_i.best_dist) begin
        beat_d.best_dist = distance;
        beat_d.best_idx  = IDX_W'(IDX);
      end
    end
  end else begin : g_absent
    // no ROM entry here: the beat only moves along
    assign beat_d = beat_i;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

FILE: rtl/core/nearest_palette_color_unit.sv
// Each input beat passes the decode stage, then one register per palette cell, on its
// way to the result beat. Throughput: one beat per cycle while the output accepts,
// set by the chain of cells, each holding its own registered stage. Each stage stalls
// only when it is full and its successor is stalled.
// Reset clears the valid bits of all stages; no item is held after reset.
module nearest_palette_color_unit import npc_pkg::*; #(
  parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  npc_in_if.sink    in_i,
  npc_out_if.source out_o
);

  logic      valid [PALETTE_ENTRIES+1];
  logic      ready [PALETTE_ENTRIES+1];
  npc_beat_t beat  [PALETTE_ENTRIES+1];

  npc_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (valid[0]),
    .ready_i (ready[0]),
    .beat_o  (beat[0])
  );

  for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
    npc_cell #(.IDX(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[i]),
      .ready_o (ready[i]),
      .beat_i  (beat[i]),
      .valid_o (valid[i+1]),
      .ready_i (ready[i+1]),
      .beat_o  (beat[i+1])
    );
  end

  assign out_o.valid                = valid[PALETTE_ENTRIES];
  assign ready[PALETTE_ENTRIES]     = out_o.ready;
  assign out_o.palette_index        = beat[PALETTE_ENTRIES].best_idx;
  assign out_o.unknown_flag         = beat[PALETTE_ENTRIES].unknown;

endmodule

FILE: rtl/core/npc_checker.sv
// Port-level checks on the nearest palette color unit, bound to the top level.
// Depends on npc_pkg and nearest_palette_color_unit.
module npc_checker import npc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [IDX_W-1:0] palette_index_i,
  input logic             unknown_flag_i
);

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(palette_index_i) && $stable(unknown_flag_i))
    else $error("result payload changed while stalled");

  a_unknown_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && unknown_flag_i |-> palette_index_i == '0)
    else $error("unknown result with nonzero index");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> palette_index_i < IDX_W'(ROM_SIZE))
    else $error("palette index beyond ROM");

endmodule

bind nearest_palette_color_unit npc_checker u_npc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .palette_index_i (out_o.palette_index),
  .unknown_flag_i  (out_o.unknown_flag)
);
